FILE: hdl/mnp_pkg.sv
// Shared types and constants for the mono note priority table.
`timescale 1ns / 1ps

package mnp_pkg;

  // Table depth default and fixed field widths
  localparam int MNP_MAX_NOTES = 32;
  localparam int NOTE_W        = 7;
  localparam int VEL_W         = 7;
  localparam int AGE_W         = 64;
  localparam int ACTIVE_W      = 8;
  localparam int OP_W          = 2;
  localparam int MODE_W        = 2;

  // Event opcodes; the fourth code is ignored
  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2
  } mnp_op_t;

  // Priority modes; the fourth code behaves as newest
  typedef enum logic [MODE_W-1:0] {
    MODE_NEWEST  = 2'd0,
    MODE_LOWEST  = 2'd1,
    MODE_HIGHEST = 2'd2
  } mnp_mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_WRITE,
    S_SHIFT,
    S_PICK,
    S_OUT
  } mnp_state_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [AGE_W-1:0]  age;
  } mnp_entry_t;

  localparam logic signed [ACTIVE_W-1:0] NO_NOTE = -8'sd1;

endpackage

FILE: hdl/mnp_if.sv
// Channel interfaces for events, results and the priority register.
`timescale 1ns / 1ps

interface mnp_evt_if;
  logic                              valid;
  logic                              ready;
  logic [mnp_pkg::OP_W-1:0]          opcode;
  logic [mnp_pkg::NOTE_W-1:0]        note_number;
  logic [mnp_pkg::VEL_W-1:0]         key_velocity;

  modport source (output valid, output opcode, output note_number, output key_velocity,
                  input ready);
  modport sink   (input valid, input opcode, input note_number, input key_velocity,
                  output ready);
endinterface

interface mnp_res_if;
  logic                              valid;
  logic                              ready;
  logic                              has_note;
  logic signed [mnp_pkg::ACTIVE_W-1:0] active_note;
  logic [mnp_pkg::VEL_W-1:0]         active_velocity;
  logic                              note_changed;
  logic                              retrigger;

  modport source (output valid, output has_note, output active_note, output active_velocity,
                  output note_changed, output retrigger, input ready);
  modport sink   (input valid, input has_note, input active_note, input active_velocity,
                  input note_changed, input retrigger, output ready);
endinterface

interface mnp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mnp_pkg::MODE_W-1:0]        priority_mode;

  modport source (output valid, output priority_mode, input ready);
  modport sink   (input valid, input priority_mode, output ready);
endinterface

FILE: hdl/mnp_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module mnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/mono_note_priority_table.sv
// Mono note priority table: a held-note list in RAM, scanned by one sequencer per event.
// Note events go into a table of up to MAX_NOTES held notes kept in a single RAM with one
// write and one registered read port. A note-on or note-off is worked through one RAM access
// per cycle: a match scan over the held entries, a write (note-on) or a shift that closes
// the gap (note-off), then a priority scan that picks the sounding note. The evt port is
// not ready while an event is worked through. All-notes-off and the unused opcode leave evt
// ready and give no result. A finished result waits in an output register, and a new event
// may be taken while it waits. The priority register may be written at any time the block
// is idle; its port is always ready.
`timescale 1ns / 1ps

module mono_note_priority_table #(
  parameter int MAX_NOTES = mnp_pkg::MNP_MAX_NOTES
) (
  input  logic      clk,
  input  logic      rst,
  mnp_evt_if.sink   evt,
  mnp_res_if.source res,
  mnp_cfg_if.sink   cfg
);

  import mnp_pkg::*;

  localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CW = $clog2(MAX_NOTES + 1);
  localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_NOTES);
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_NOTES - 1);

  mnp_state_t state, state_next;

  // Table and selection state
  logic [CW-1:0]              count;
  logic [AGE_W-1:0]           age_counter;
  logic signed [ACTIVE_W-1:0] current_note;
  logic [VEL_W-1:0]           current_vel;
  logic [MODE_W-1:0]          prio_mode;

  // Latched event
  logic              on_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;
  logic              had_q;

  // Scan pipeline
  logic [CW-1:0] scan_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic          found;
  logic [IW-1:0] slot;
  mnp_entry_t    best;
  logic          best_have;

  // Flags of the event in progress
  logic          pick_chg;
  logic          pick_rtg;

  // Result register
  logic                       res_valid;
  logic                       res_has;
  logic signed [ACTIVE_W-1:0] res_note;
  logic [VEL_W-1:0]           res_vel;
  logic                       res_chg;
  logic                       res_rtg;

  // Control and datapath wires
  logic       issue;
  logic       scan_done;
  logic       load_out;
  logic       evt_take;
  logic       ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  mnp_entry_t ram_wdata;
  mnp_entry_t rd_entry;
  logic [IW-1:0] new_slot;
  logic       better;
  logic signed [ACTIVE_W-1:0] new_note;
  logic [VEL_W-1:0]           new_vel;
  logic       is_repeat;

  mnp_ram #(
    .WIDTH ($bits(mnp_entry_t)),
    .DEPTH (MAX_NOTES)
  ) u_mnp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign cfg.ready = 1'b1;
  assign evt_take  = evt.valid && evt.ready;

  // Slot for a note-on: refresh, append, or overwrite the last slot
  always_comb begin
    if (found) begin
      new_slot = slot;
    end else if (count < CNT_MAX) begin
      new_slot = count[IW-1:0];
    end else begin
      new_slot = LAST_SLOT;
    end
  end

  // Priority compare of the entry just read against the best so far
  always_comb begin
    unique case (prio_mode)
      MODE_LOWEST:  better = rd_entry.note < best.note;
      MODE_HIGHEST: better = rd_entry.note > best.note;
      default:      better = rd_entry.age > best.age;
    endcase
  end

  // Selection and flags at the end of the priority scan
  always_comb begin
    if (count == '0) begin
      new_note = NO_NOTE;
      new_vel  = '0;
    end else begin
      new_note = signed'({1'b0, best.note});
      new_vel  = best.vel;
    end
    is_repeat = current_note == signed'({1'b0, note_q});
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (evt_take && (evt.opcode == OP_NOTE_ON || evt.opcode == OP_NOTE_OFF)) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (scan_done) begin
          if (on_q) begin
            state_next = S_WRITE;
          end else if (found) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_PICK;
          end
        end
      end
      S_WRITE: state_next = S_PICK;
      S_SHIFT: begin
        if (scan_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (scan_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs: RAM port, scan issue and handshakes
  always_comb begin
    evt.ready = state == S_IDLE;
    issue     = (state == S_FIND || state == S_SHIFT || state == S_PICK) && (scan_idx < count);
    scan_done = !issue && !pend;
    load_out  = (state == S_OUT) && (!res_valid || res.ready);
    ram_raddr = scan_idx[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = new_slot;
    ram_wdata = rd_entry;
    unique case (state)
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = new_slot;
        ram_wdata = '{note: note_q, vel: vel_q, age: age_counter};
      end
      S_SHIFT: begin
        ram_we    = pend;
        ram_waddr = pend_idx - IW'(1);
        ram_wdata = rd_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      age_counter  <= '0;
      current_note <= NO_NOTE;
      current_vel  <= '0;
      prio_mode    <= MODE_NEWEST;
      res_valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state <= state_next;

      // Register write
      if (cfg.valid && cfg.ready) begin
        prio_mode <= cfg.priority_mode;
      end

      // Advance the scan pipeline
      pend     <= issue;
      pend_idx <= scan_idx[IW-1:0];
      if (issue) begin
        scan_idx <= scan_idx + CW'(1);
      end

      // Load a finished result, or drop one once taken
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (evt_take) begin
            on_q     <= evt.opcode == OP_NOTE_ON;
            note_q   <= evt.note_number;
            vel_q    <= evt.key_velocity;
            had_q    <= count != '0;
            scan_idx <= '0;
            found    <= 1'b0;
            if (evt.opcode == OP_NOTE_ON) begin
              age_counter <= age_counter + AGE_W'(1);
            end else if (evt.opcode == OP_ALL_OFF) begin
              count        <= '0;
              current_note <= NO_NOTE;
              current_vel  <= '0;
            end
          end
        end
        S_FIND: begin
          // Hold the first matching index
          if (pend && !found && rd_entry.note == note_q) begin
            found <= 1'b1;
            slot  <= pend_idx;
          end
          if (scan_done) begin
            if (!on_q && found) begin
              scan_idx <= CW'(slot) + CW'(1);
            end else begin
              scan_idx <= '0;
            end
            best_have <= 1'b0;
          end
        end
        S_WRITE: begin
          if (!found && count < CNT_MAX) begin
            count <= count + CW'(1);
          end
          scan_idx  <= '0;
          best_have <= 1'b0;
        end
        S_SHIFT: begin
          if (scan_done) begin
            count     <= count - CW'(1);
            scan_idx  <= '0;
            best_have <= 1'b0;
          end
        end
        S_PICK: begin
          // Keep the first best entry; later ties lose
          if (pend && (!best_have || better)) begin
            best      <= rd_entry;
            best_have <= 1'b1;
          end
          if (scan_done) begin
            current_note <= new_note;
            current_vel  <= new_vel;
            pick_chg     <= (new_note != current_note) || (on_q && is_repeat);
            pick_rtg     <= on_q && (!had_q || is_repeat);
          end
        end
        S_OUT: begin
          if (load_out) begin
            res_has  <= count != '0;
            res_note <= current_note;
            res_vel  <= current_vel;
            res_chg  <= pick_chg;
            res_rtg  <= pick_rtg;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res.valid           = res_valid;
  assign res.has_note        = res_has;
  assign res.active_note     = res_note;
  assign res.active_velocity = res_vel;
  assign res.note_changed    = res_chg;
  assign res.retrigger       = res_rtg;

endmodule

FILE: hdl/mnp_checker.sv
// Port-level checks for the mono note priority table, bound to the top level.
`timescale 1ns / 1ps

module mnp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            evt_valid,
  input logic                            evt_ready,
  input logic [mnp_pkg::OP_W-1:0]        evt_opcode,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic                            res_has_note,
  input logic [mnp_pkg::ACTIVE_W-1:0]    res_active_note,
  input logic [mnp_pkg::VEL_W-1:0]       res_active_velocity,
  input logic                            res_note_changed,
  input logic                            res_retrigger
);

  import mnp_pkg::*;

  // Stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_active_note)
      && $stable(res_active_velocity) && $stable(res_has_note))
    else $error("result changed while stalled");

  // Note-on or note-off starts a scan, so the block is busy next cycle
  assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready && (evt_opcode == OP_NOTE_ON || evt_opcode == OP_NOTE_OFF)
      |=> !evt_ready)
    else $error("ready after a note event");

  // All-notes-off and the unused opcode finish at once
  assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready && !(evt_opcode == OP_NOTE_ON || evt_opcode == OP_NOTE_OFF)
      |=> evt_ready)
    else $error("busy after a resultless event");

  // Retrigger only comes with a sounding, changed note
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_retrigger |-> res_note_changed && res_has_note)
    else $error("retrigger without a sounding note");

  // No held note reads as no note and zero velocity
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_has_note |-> res_active_note == NO_NOTE && res_active_velocity == '0)
    else $error("empty table reports a note");

endmodule

bind mono_note_priority_table mnp_checker u_mnp_checker (
  .clk                 (clk),
  .rst                 (rst),
  .evt_valid           (evt.valid),
  .evt_ready           (evt.ready),
  .evt_opcode          (evt.opcode),
  .res_valid           (res.valid),
  .res_ready           (res.ready),
  .res_has_note        (res.has_note),
  .res_active_note     (res.active_note),
  .res_active_velocity (res.active_velocity),
  .res_note_changed    (res.note_changed),
  .res_retrigger       (res.retrigger)
);
